/* sv/ncpm_pkg.sv */
// shared types and constants of the nibble-coded poll master
package ncpm_pkg;

    localparam int MAX_CHANNELS_DEF = 32;

    localparam logic [7:0] BYTE_OUT_CMD   = 8'h04;
    localparam logic [7:0] BYTE_IN_CMD    = 8'h05;
    localparam logic [7:0] BYTE_TIMING    = 8'h06;
    localparam logic [3:0] TAG_DATA       = 4'h3;
    localparam logic [3:0] TAG_SUM        = 4'h4;
    localparam logic [7:0] BYTE_ACK_OK    = 8'h50;
    localparam logic [7:0] BYTE_ACK_NAK   = 8'h00;
    localparam logic [7:0] BYTE_ACK_R     = 8'h51;
    localparam logic [7:0] BYTE_ACK_P     = 8'h52;
    localparam logic [7:0] BYTE_PAD       = 8'hff;
    localparam logic [7:0] NIBBLE_MASK    = 8'h0f;
    localparam logic [1:0] PAD_REFILL     = 2'd3;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_NO_REPLY = 3'd1;
    localparam logic [2:0] ERR_CHECKSUM = 3'd2;
    localparam logic [2:0] ERR_R_CODE   = 3'd3;
    localparam logic [2:0] ERR_P_CODE   = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd5;
    localparam logic [2:0] ERR_OVERRUN  = 3'd6;

    localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
    localparam logic [1:0] REG_TIMING_VALUE = 2'd2;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_RX     = 3'd1,
        CMD_TX     = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_code_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_IN_DATA = 3'd1,
        PH_ECHO    = 3'd2,
        PH_ACK     = 3'd3,
        PH_TIMING  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        TX_NONE,
        TX_LIT,
        TX_DATA_HI,
        TX_DATA_LO,
        TX_SUM_HI,
        TX_SUM_LO
    } tx_kind_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] rx_data;
        logic       rx_fault;
        logic [4:0] channel;
        logic [7:0] value;
    } cmd_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_data;
        logic       drive_enable;
        logic [7:0] read_value;
        logic [2:0] input_status;
        logic [2:0] output_status;
        logic [5:0] input_fail_position;
        logic [5:0] output_fail_position;
        logic       busy_res;
    } res_t;

    // work handed from the control stage to the data stage
    typedef struct packed {
        tx_kind_t   kind;
        logic [7:0] lit;
        logic       sum_clear;
        logic       sum_add_rx;
        logic [7:0] rx_data;
        logic       read_sel;
        logic       drive_enable;
        logic [2:0] input_status;
        logic [2:0] output_status;
        logic [5:0] input_fail_position;
        logic [5:0] output_fail_position;
        logic       busy_res;
    } stage_t;

endpackage

/* sv/nibble_coded_io_poll_master_core.sv */
// nibble-coded remote i/o poll master: control stage, store memories, data stage
// a result passes through the stage register s1_reg and then the result register res_reg
// throughput: one command per cycle unless res_stall backs up the pipeline; the input and
//   output stores are read at the command transfer and the byte is formed from the registered read data
// reset: all control state, counts, errors and store valid bits clear at once;
//   never-written store entries read as zero
module nibble_coded_io_poll_master_core #(
    parameter int MAX_CHANNELS = ncpm_pkg::MAX_CHANNELS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  ncpm_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_stall,
    output ncpm_pkg::res_t  res,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data
);
    import ncpm_pkg::*;

    localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(2 * MAX_CHANNELS + 4);

    // configuration
    logic [5:0] input_count_reg, output_count_reg;
    logic [7:0] timing_value_reg;

    // control state
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] byte_counter_reg, byte_counter_next;
    logic [CNT_W-1:0] frame_position_reg, frame_position_next;
    logic [1:0]       pad_slots_reg, pad_slots_next;
    logic             frame_sent_reg, frame_sent_next;
    logic             line_active_reg, line_active_next;
    logic             timing_pending_reg, timing_pending_next;
    logic [2:0]       input_error_reg, input_error_next;
    logic [2:0]       output_error_reg, output_error_next;
    logic [5:0]       input_index_reg, input_index_next;
    logic [5:0]       output_index_reg, output_index_next;
    logic [3:0]       hi_nibble_reg, hi_nibble_next;

    // stores
    logic [7:0]              in_mem [MAX_CHANNELS];
    logic [7:0]              out_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] in_ok_reg, out_ok_reg;
    logic [7:0]              in_rd_reg, out_rd_reg;
    logic                    in_rd_ok_reg, out_rd_ok_reg;

    logic          in_we, out_we;
    logic [AW-1:0] in_waddr, out_waddr, in_raddr, out_raddr;
    logic [7:0]    in_wdata;

    // pipeline
    logic   s1_valid_reg, res_valid_reg, advance, accept;
    stage_t s1_reg, s1_next;
    res_t   res_reg, res_next;
    logic [7:0] running_sum_reg, running_sum_next;

    logic [CNT_W-1:0] n_in, n_out;
    logic             ch_ok;

    assign cfg_ready = 1'b1;
    assign advance   = !res_valid_reg || !res_stall;
    assign cmd_stall = s1_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign n_in  = (7'(input_count_reg) > 7'(MAX_CHANNELS)) ?
                   CNT_W'(MAX_CHANNELS) : CNT_W'(input_count_reg);
    assign n_out = (7'(output_count_reg) > 7'(MAX_CHANNELS)) ?
                   CNT_W'(MAX_CHANNELS) : CNT_W'(output_count_reg);
    assign ch_ok = {2'b00, cmd.channel} < 7'(MAX_CHANNELS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg  <= '0;
            output_count_reg <= '0;
            timing_value_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INPUT_COUNT:  input_count_reg  <= cfg_data[5:0];
                REG_OUTPUT_COUNT: output_count_reg <= cfg_data[5:0];
                REG_TIMING_VALUE: timing_value_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control stage: sequencing, counters and error bookkeeping
    always_comb
    begin
        logic       do_op, do_bo, do_start, do_send, do_idle;
        phase_t     start_ph, ph0;
        logic [CNT_W-1:0] k, two_n;
        logic [7:0] t_hi, t_lo, t_sum;
        logic       fb_ok;

        phase_next          = phase_reg;
        byte_counter_next   = byte_counter_reg;
        frame_position_next = frame_position_reg;
        pad_slots_next      = pad_slots_reg;
        frame_sent_next     = frame_sent_reg;
        line_active_next    = line_active_reg;
        timing_pending_next = timing_pending_reg;
        input_error_next    = input_error_reg;
        output_error_next   = output_error_reg;
        input_index_next    = input_index_reg;
        output_index_next   = output_index_reg;
        hi_nibble_next      = hi_nibble_reg;
        in_we    = 1'b0;
        in_waddr = byte_counter_reg[AW:1];
        in_wdata = '0;
        out_we    = 1'b0;
        out_waddr = AW'(cmd.channel);
        in_raddr  = AW'(cmd.channel);
        out_raddr = '0;
        s1_next = '0;
        s1_next.kind    = TX_NONE;
        s1_next.rx_data = cmd.rx_data;
        do_op = 1'b0; do_bo = 1'b0; do_start = 1'b0; do_send = 1'b0; do_idle = 1'b0;
        start_ph = PH_IDLE;
        ph0 = phase_reg;
        k = '0;
        two_n = '0;
        fb_ok = 1'b0;
        t_hi  = {TAG_DATA, timing_value_reg[7:4]};
        t_lo  = {TAG_DATA, timing_value_reg[3:0]};
        t_sum = t_hi + t_lo;

        case (cmd.command)
            CMD_START:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    input_error_next = ERR_OVERRUN;
                    input_index_next = 6'(byte_counter_reg >> 1);
                    do_op = 1'b1;
                end
                else if (n_in != '0)
                begin
                    byte_counter_next = '0;
                    s1_next.sum_clear = 1'b1;
                    do_start = 1'b1;
                    start_ph = PH_IN_DATA;
                end
                else
                    do_op = 1'b1;
            end
            CMD_RX:
            begin
                if (!cmd.rx_fault && line_active_reg && frame_sent_reg)
                begin
                    pad_slots_next = PAD_REFILL;
                    case (phase_reg)
                        PH_IN_DATA:
                        begin
                            s1_next.sum_add_rx = 1'b1;
                            in_we = 1'b1;
                            if (byte_counter_reg[0])
                                in_wdata = {hi_nibble_reg, cmd.rx_data[3:0]};
                            else
                            begin
                                in_wdata = {cmd.rx_data[3:0], 4'h0};
                                hi_nibble_next = cmd.rx_data[3:0];
                            end
                            byte_counter_next = byte_counter_reg + 1'b1;
                            if (byte_counter_next >= (n_in << 1))
                            begin
                                do_start = 1'b1;
                                start_ph = PH_ECHO;
                            end
                        end
                        PH_ECHO:
                        begin
                            input_error_next = ERR_CHECKSUM;
                            do_op = 1'b1;
                        end
                        PH_ACK:
                        begin
                            if (cmd.rx_data != BYTE_ACK_OK)
                            begin
                                if (cmd.rx_data == BYTE_ACK_NAK)
                                    output_error_next = ERR_CHECKSUM;
                                else if (cmd.rx_data == BYTE_ACK_R)
                                begin
                                    output_error_next   = ERR_R_CODE;
                                    timing_pending_next = 1'b1;
                                end
                                else if (cmd.rx_data == BYTE_ACK_P)
                                begin
                                    output_error_next   = ERR_P_CODE;
                                    timing_pending_next = 1'b1;
                                end
                                else
                                    output_error_next = ERR_UNKNOWN;
                                output_index_next = 6'(byte_counter_reg);
                            end
                            byte_counter_next = byte_counter_reg + 1'b1;
                            if (byte_counter_next >= n_out)
                                do_idle = 1'b1;
                        end
                        PH_TIMING:
                        begin
                            output_error_next = ERR_CHECKSUM;
                            do_idle = 1'b1;
                            do_bo = 1'b1;
                        end
                        default: do_idle = 1'b1;
                    endcase
                end
            end
            CMD_TX:
            begin
                if (line_active_reg)
                begin
                    if (!frame_sent_reg)
                        do_send = 1'b1;
                    else if (pad_slots_reg != '0)
                    begin
                        s1_next.kind = TX_LIT;
                        s1_next.lit  = BYTE_PAD;
                        pad_slots_next = pad_slots_reg - 1'b1;
                    end
                    else
                    begin
                        do_idle = 1'b1;
                        case (ph0)
                            PH_IN_DATA:
                            begin
                                input_error_next = ERR_NO_REPLY;
                                input_index_next = 6'(byte_counter_reg >> 1);
                                do_op = 1'b1;
                            end
                            PH_ECHO:   do_op = 1'b1;
                            PH_ACK:
                            begin
                                output_error_next = ERR_NO_REPLY;
                                output_index_next = 6'(byte_counter_reg);
                            end
                            PH_TIMING:
                            begin
                                timing_pending_next = 1'b0;
                                do_bo = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            CMD_WRITE: out_we = ch_ok;
            CMD_READ:  s1_next.read_sel = ch_ok;
            CMD_CLEAR:
            begin
                input_error_next  = ERR_OK;
                output_error_next = ERR_OK;
                input_index_next  = '0;
                output_index_next = '0;
            end
            default: ;
        endcase

        if (do_idle || do_op)
        begin
            phase_next       = PH_IDLE;
            line_active_next = 1'b0;
            frame_sent_next  = 1'b0;
            pad_slots_next   = '0;
        end
        if (do_op && n_out != '0)
        begin
            if (timing_pending_next && timing_value_reg != '0)
            begin
                do_start = 1'b1;
                start_ph = PH_TIMING;
            end
            else
            begin
                timing_pending_next = 1'b0;
                do_bo = 1'b1;
            end
        end
        if (do_bo)
        begin
            if (n_out == '0)
            begin
                phase_next       = PH_IDLE;
                line_active_next = 1'b0;
                frame_sent_next  = 1'b0;
                pad_slots_next   = '0;
            end
            else
            begin
                s1_next.sum_clear = 1'b1;
                byte_counter_next = '0;
                do_start = 1'b1;
                start_ph = PH_ACK;
            end
        end
        if (do_start)
        begin
            phase_next          = start_ph;
            frame_position_next = '0;
            frame_sent_next     = 1'b0;
            line_active_next    = 1'b1;
            pad_slots_next      = '0;
            do_send = 1'b1;
        end

        // next frame byte, or the first pad once the frame is out
        if (do_send)
        begin
            k = frame_position_next;
            two_n = n_out << 1;
            s1_next.kind = TX_LIT;
            fb_ok = 1'b1;
            case (phase_next)
                PH_IN_DATA:
                begin
                    fb_ok = (k == '0);
                    s1_next.lit = BYTE_IN_CMD;
                end
                PH_ECHO:
                begin
                    fb_ok = (k <= CNT_W'(1));
                    s1_next.kind = (k == '0) ? TX_SUM_HI : TX_SUM_LO;
                end
                PH_TIMING:
                begin
                    if (k == CNT_W'(0))      s1_next.lit = BYTE_TIMING;
                    else if (k == CNT_W'(1)) s1_next.lit = t_hi;
                    else if (k == CNT_W'(2)) s1_next.lit = t_lo;
                    else if (k == CNT_W'(3)) s1_next.lit = {TAG_SUM, t_sum[7:4]};
                    else if (k == CNT_W'(4)) s1_next.lit = {TAG_SUM, t_sum[3:0]};
                    else fb_ok = 1'b0;
                end
                PH_ACK:
                begin
                    out_raddr = AW'((k - 1'b1) >> 1);
                    if (k == '0)
                        s1_next.lit = BYTE_OUT_CMD;
                    else if (k <= two_n)
                        s1_next.kind = k[0] ? TX_DATA_HI : TX_DATA_LO;
                    else if (k == two_n + 1'b1)
                        s1_next.kind = TX_SUM_HI;
                    else if (k == two_n + 2'd2)
                        s1_next.kind = TX_SUM_LO;
                    else
                        fb_ok = 1'b0;
                end
                default: fb_ok = 1'b0;
            endcase
            if (fb_ok)
                frame_position_next = frame_position_next + 1'b1;
            else
            begin
                frame_sent_next = 1'b1;
                s1_next.kind = TX_LIT;
                s1_next.lit  = BYTE_PAD;
                pad_slots_next = PAD_REFILL;
            end
        end

        s1_next.drive_enable         = line_active_next && !frame_sent_next;
        s1_next.input_status         = input_error_next;
        s1_next.output_status        = output_error_next;
        s1_next.input_fail_position  = input_index_next;
        s1_next.output_fail_position = output_index_next;
        s1_next.busy_res             = phase_next != PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            byte_counter_reg   <= '0;
            frame_position_reg <= '0;
            pad_slots_reg      <= '0;
            frame_sent_reg     <= 1'b0;
            line_active_reg    <= 1'b0;
            timing_pending_reg <= 1'b0;
            input_error_reg    <= '0;
            output_error_reg   <= '0;
            input_index_reg    <= '0;
            output_index_reg   <= '0;
            hi_nibble_reg      <= '0;
            in_ok_reg          <= '0;
            out_ok_reg         <= '0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            byte_counter_reg   <= byte_counter_next;
            frame_position_reg <= frame_position_next;
            pad_slots_reg      <= pad_slots_next;
            frame_sent_reg     <= frame_sent_next;
            line_active_reg    <= line_active_next;
            timing_pending_reg <= timing_pending_next;
            input_error_reg    <= input_error_next;
            output_error_reg   <= output_error_next;
            input_index_reg    <= input_index_next;
            output_index_reg   <= output_index_next;
            hi_nibble_reg      <= hi_nibble_next;
            if (in_we)
                in_ok_reg[in_waddr] <= 1'b1;
            if (out_we)
                out_ok_reg[out_waddr] <= 1'b1;
        end
    end

    // store memories, read data registered at the command transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (in_we)
                in_mem[in_waddr] <= in_wdata;
            in_rd_reg    <= in_mem[in_raddr];
            in_rd_ok_reg <= in_ok_reg[in_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (out_we)
                out_mem[out_waddr] <= cmd.value;
            out_rd_reg    <= out_mem[out_raddr];
            out_rd_ok_reg <= out_ok_reg[out_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
    end

    // data stage: running sum and transmit byte
    always_comb
    begin
        logic [7:0] sum1, sum2, v, b;
        sum1 = s1_reg.sum_clear ? 8'h00 : running_sum_reg;
        sum2 = sum1 + (s1_reg.sum_add_rx ? s1_reg.rx_data : 8'h00);
        v    = out_rd_ok_reg ? out_rd_reg : 8'h00;
        case (s1_reg.kind)
            TX_LIT:     b = s1_reg.lit;
            TX_DATA_HI: b = {TAG_DATA, v[7:4]};
            TX_DATA_LO: b = {TAG_DATA, v[3:0]};
            TX_SUM_HI:  b = {TAG_SUM, sum2[7:4]};
            TX_SUM_LO:  b = {TAG_SUM, sum2[3:0]};
            default:    b = 8'h00;
        endcase
        running_sum_next = (s1_reg.kind == TX_DATA_HI || s1_reg.kind == TX_DATA_LO) ?
                           sum2 + b : sum2;
        res_next.tx_valid             = s1_reg.kind != TX_NONE;
        res_next.tx_data              = b;
        res_next.drive_enable         = s1_reg.drive_enable;
        res_next.read_value           = (s1_reg.read_sel && in_rd_ok_reg) ?
                                        in_rd_reg : 8'h00;
        res_next.input_status         = s1_reg.input_status;
        res_next.output_status        = s1_reg.output_status;
        res_next.input_fail_position  = s1_reg.input_fail_position;
        res_next.output_fail_position = s1_reg.output_fail_position;
        res_next.busy_res             = s1_reg.busy_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            running_sum_reg <= '0;
        end
        else
        begin
            if (!cmd_stall)
                s1_valid_reg <= cmd_valid;
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                    running_sum_reg <= running_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
            res_reg <= res_next;
    end

    // the line driver is only on during an exchange
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (!res_reg.drive_enable || res_reg.busy_res))
        else $error("driver on while not busy");

    // no byte means a zero data field
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.tx_valid |-> res_reg.tx_data == 8'h00)
        else $error("tx data without tx valid");

    // an idle sequencer never keeps the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (!line_active_reg && !frame_sent_reg))
        else $error("line held while idle");

    // the command side stalls only behind a full data stage
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (s1_valid_reg && res_valid_reg))
        else $error("stall without backlog");

endmodule
